// ----- hdl/rpcq_pkg.sv -----
// Shared types and constants for the read-priority command queue.
// Used by every module under hdl/; depends on nothing.
`default_nettype none

package rpcq_pkg;

  // Ring depths must be powers of two: pointers run modulo twice the depth.
  localparam int RING_DEPTH  = 128;
  localparam int ORDER_DEPTH = 256;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int ORDER_AW    = $clog2(ORDER_DEPTH);

  // Command queue between the front and back parts
  localparam int CMD_Q_DEPTH = 2;
  localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);
  localparam int CMD_Q_CW    = $clog2(CMD_Q_DEPTH + 1);

  localparam int LBA_W   = 32;
  localparam int CNT_W   = 17;
  localparam int ENTRY_W = LBA_W + CNT_W;

  localparam logic [LBA_W-1:0] LBA28_MASK  = 32'h0FFF_FFFF;
  localparam logic [CNT_W-1:0] CNT_DEF_28  = 17'h0_0100;
  localparam logic [CNT_W-1:0] CNT_DEF_48  = 17'h1_0000;
  localparam logic [CNT_W-1:0] CNT_ZERO_AS = 17'h1_0000;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POP_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHS_HEADS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHS_SECTORS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LBA     = 2'd3;

  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_IGNORED = 3'd1,
    ST_RANGE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_POPPED  = 3'd4,
    ST_EMPTY   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,  // translated command to store
    CMD_POP    = 2'd1,
    CMD_REPORT = 2'd2   // status settled in the front part
  } cmd_kind_t;

  typedef struct packed {
    logic        func;
    logic        class_write;
    logic        class_read;
    logic        addr_28bit;
    logic        addr_48bit;
    logic        no_sector_count;
    logic [31:0] fis_word1;
    logic [7:0]  fis_lba_high;
    logic [15:0] fis_count;
  } in_item_t;

  typedef struct packed {
    cmd_kind_t        kind;
    status_t          status;
    logic             is_write;
    logic [LBA_W-1:0] lba;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [LBA_W-1:0] lba;
    logic [CNT_W-1:0] cnt;
    logic             is_write;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/rpcq_front.sv -----
// Front part: accepts items, translates CHS/28-bit/48-bit addresses, checks range.
// Depends on rpcq_pkg.
`default_nettype none

module rpcq_front import rpcq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  input  logic [4:0]  chs_heads,
  input  logic [7:0]  chs_sectors,
  input  logic [31:0] max_lba,
  output logic        q_push,
  output cmd_t        q_data,
  input  logic        q_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL1 = 4'b0010,
    F_MUL2 = 4'b0100,
    F_CHK  = 4'b1000
  } front_state_t;

  front_state_t state, state_next;
  in_item_t     item;
  logic [20:0]  prod1;
  logic [28:0]  prod2;

  logic [LBA_W-1:0] lba_chs, lba;
  logic [CNT_W-1:0] cnt;
  logic [33:0]      range_sum, range_lim;
  logic             out_of_range;

  assign in_ready = (state == F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // CHS chain: (cyl * heads + head) * sectors, one multiply per cycle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
    if (state == F_MUL1) begin
      prod1 <= 21'({5'd0, item.fis_word1[23:8]} * {16'd0, chs_heads})
               + 21'(item.fis_word1[27:24]);
    end
    if (state == F_MUL2) begin
      prod2 <= 29'({8'd0, prod1} * {21'd0, chs_sectors});
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (in_valid) begin
          state_next = in_item.func ? F_CHK : F_MUL1;
        end
      end
      F_MUL1: state_next = F_MUL2;
      F_MUL2: state_next = F_CHK;
      F_CHK: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    // sector 0 wraps below zero, as the address arithmetic is modulo 2^32
    lba_chs = 32'(prod2) + 32'(item.fis_word1[7:0]) - 32'd1;
    lba     = '0;
    cnt     = '0;
    priority if (item.addr_28bit) begin
      lba = item.fis_word1[30] ? (item.fis_word1 & LBA28_MASK) : lba_chs;
      cnt = {9'd0, item.fis_count[7:0]};
      if (cnt == '0 && !item.no_sector_count) begin
        cnt = CNT_DEF_28;
      end
    end else if (item.addr_48bit) begin
      lba = {item.fis_lba_high, item.fis_word1[23:0]};
      cnt = {1'b0, item.fis_count};
      if (cnt == '0 && !item.no_sector_count) begin
        cnt = CNT_DEF_48;
      end
    end
    range_sum    = 34'(lba) + 34'(cnt);
    range_lim    = 34'(max_lba) + 34'd1;
    out_of_range = !item.no_sector_count && (range_sum > range_lim);
  end

  always_comb begin
    q_data.kind     = CMD_PUSH;
    q_data.status   = ST_QUEUED;
    q_data.is_write = item.class_write;
    q_data.lba      = lba;
    q_data.cnt      = cnt;
    priority if (item.func) begin
      q_data.kind = CMD_POP;
    end else if (!item.class_write && !item.class_read) begin
      q_data.kind   = CMD_REPORT;
      q_data.status = ST_IGNORED;
    end else if (out_of_range) begin
      q_data.kind   = CMD_REPORT;
      q_data.status = ST_RANGE;
    end
  end

  assign q_push = (state == F_CHK) && !q_full;

endmodule

`default_nettype wire

// ----- hdl/rpcq_cmd_fifo.sv -----
// Short command queue between front and back parts.
// Depends on rpcq_pkg.
`default_nettype none

module rpcq_cmd_fifo import rpcq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t                entries [CMD_Q_DEPTH];
  logic [CMD_Q_AW-1:0] wr_ptr, rd_ptr;
  logic [CMD_Q_CW-1:0] fill;

  assign full     = (fill == CMD_Q_CW'(CMD_Q_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == CMD_Q_AW'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == CMD_Q_AW'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rpcq_back.sv -----
// Back part: read, write and arrival-order rings, push/pop execution, result register.
// Depends on rpcq_pkg.
`default_nettype none

module rpcq_back import rpcq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pop_mode,
  input  logic    q_empty,
  input  cmd_t    q_data,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RD   = 2'b10
  } back_state_t;

  back_state_t state, state_next;

  logic [ENTRY_W-1:0]   read_mem  [RING_DEPTH];
  logic [ENTRY_W-1:0]   write_mem [RING_DEPTH];
  logic [ENTRY_W:0]     order_mem [ORDER_DEPTH];
  logic [ENTRY_W-1:0]   rd_read, rd_write;
  logic [ENTRY_W:0]     rd_order;

  logic [RING_AW:0]  rh, rt, wh, wt, rh_next, rt_next, wh_next, wt_next;
  logic [ORDER_AW:0] oh, ot, oh_next, ot_next;

  logic r_any, w_any, o_any, r_full, w_full, o_full;
  logic slot_free, done;
  logic we_read, we_write, we_order;
  logic [ENTRY_W-1:0] new_entry, pop_entry;
  logic               pop_is_wr;
  result_t            res;

  assign r_any  = (rh != rt);
  assign w_any  = (wh != wt);
  assign o_any  = (oh != ot);
  assign r_full = (rh[RING_AW] != rt[RING_AW]) && (rh[RING_AW-1:0] == rt[RING_AW-1:0]);
  assign w_full = (wh[RING_AW] != wt[RING_AW]) && (wh[RING_AW-1:0] == wt[RING_AW-1:0]);
  assign o_full = (oh[ORDER_AW] != ot[ORDER_AW]) && (oh[ORDER_AW-1:0] == ot[ORDER_AW-1:0]);

  assign slot_free = !out_valid || out_ready;
  assign new_entry = {q_data.cnt, q_data.lba};
  assign q_pop     = done;

  always_comb begin
    state_next = state;
    done       = 1'b0;
    we_read    = 1'b0;
    we_write   = 1'b0;
    we_order   = 1'b0;
    rh_next    = rh;
    rt_next    = rt;
    wh_next    = wh;
    wt_next    = wt;
    oh_next    = oh;
    ot_next    = ot;
    pop_entry  = '0;
    pop_is_wr  = 1'b0;
    res        = '0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          priority if (q_data.kind == CMD_POP) begin
            // wait in B_RD for the registered ring reads at the heads
            state_next = B_RD;
          end else if (slot_free) begin
            done = 1'b1;
            priority if (q_data.kind == CMD_REPORT) begin
              res.status = q_data.status;
            end else if (o_full || (q_data.is_write ? w_full : r_full)) begin
              res.status = ST_FULL;
            end else begin
              res.status = ST_QUEUED;
              we_order   = 1'b1;
              ot_next    = ot + 1'b1;
              if (q_data.is_write) begin
                we_write = 1'b1;
                wt_next  = wt + 1'b1;
              end else begin
                we_read = 1'b1;
                rt_next = rt + 1'b1;
              end
            end
          end
        end
      end
      B_RD: begin
        if (slot_free) begin
          done       = 1'b1;
          state_next = B_IDLE;
          res.status = ST_POPPED;
          if (pop_mode) begin
            priority if (r_any) begin
              pop_entry = rd_read;
              rh_next   = rh + 1'b1;
            end else if (w_any) begin
              pop_entry = rd_write;
              pop_is_wr = 1'b1;
              wh_next   = wh + 1'b1;
            end else begin
              res.status = ST_EMPTY;
            end
            if ((r_any || w_any) && o_any) begin
              oh_next = oh + 1'b1;
            end
          end else begin
            if (o_any) begin
              pop_entry = rd_order[ENTRY_W-1:0];
              pop_is_wr = rd_order[ENTRY_W];
              oh_next   = oh + 1'b1;
              if (pop_is_wr && w_any) begin
                wh_next = wh + 1'b1;
              end
              if (!pop_is_wr && r_any) begin
                rh_next = rh + 1'b1;
              end
            end else begin
              res.status = ST_EMPTY;
            end
          end
          if (res.status == ST_POPPED) begin
            res.lba      = pop_entry[LBA_W-1:0];
            res.cnt      = pop_entry[ENTRY_W-1:LBA_W];
            res.is_write = pop_is_wr;
            if (res.cnt == '0) begin
              res.cnt = CNT_ZERO_AS;
            end
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rh        <= '0;
      rt        <= '0;
      wh        <= '0;
      wt        <= '0;
      oh        <= '0;
      ot        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rh    <= rh_next;
      rt    <= rt_next;
      wh    <= wh_next;
      wt    <= wt_next;
      oh    <= oh_next;
      ot    <= ot_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res <= res;
    end
  end

  // Ring memories, reads always at the current heads
  always_ff @(posedge clk) begin
    if (we_read) begin
      read_mem[rt[RING_AW-1:0]] <= new_entry;
    end
    rd_read <= read_mem[rh[RING_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_write) begin
      write_mem[wt[RING_AW-1:0]] <= new_entry;
    end
    rd_write <= write_mem[wh[RING_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_order) begin
      order_mem[ot[ORDER_AW-1:0]] <= {q_data.is_write, new_entry};
    end
    rd_order <= order_mem[oh[ORDER_AW-1:0]];
  end

endmodule

`default_nettype wire

// ----- hdl/read_priority_command_queue_top.sv -----
// Top level of the read-priority command queue: ports, config registers, assertions.
// Depends on rpcq_pkg, rpcq_front, rpcq_cmd_fifo, rpcq_back.
`default_nettype none

// Host command queue. A push (tuser func = 0) translates the command address
// (CHS through the heads/sectors registers, 28-bit LBA or 48-bit LBA cut to
// 32 bits), applies the zero-count defaults and the range check, and stores
// it in the read or write ring (128 entries each) and the arrival-order ring
// (256 entries); every push returns one status transfer. A pop (func = 1)
// returns the oldest read first and then writes (pop_mode = 1), or strict
// arrival order (pop_mode = 0); an empty queue reports status empty. Each
// item gives exactly one result transfer. A push passes through the front
// part's accept state, two registered multiplies of the CHS translation
// and the range check, which waits while the command queue is full; the
// back part then registers its result once the output slot is free. The
// front part takes the next item once it is back in its idle state. A pop
// goes from the accept state straight to the check state; the back part
// waits in B_RD for the registered ring read. A two-entry queue
// separates translation from ring access, and the output register lets the
// next item be accepted while a result waits. Config writes are accepted
// every cycle and are meant to happen only while the block is idle.
module read_priority_command_queue_top import rpcq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [31:0] fis_word1, [39:32] fis_lba_high, [55:40] fis_count
  input  logic [55:0]          s_axis_tdata,
  // [0] func, [1] class_write, [2] class_read, [3] addr_28bit, [4] addr_48bit,
  // [5] no_sector_count
  input  logic [5:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] out_lba, [48:32] out_count, [49] out_is_write, [55:50] zero
  output logic [55:0]          m_axis_tdata,
  // [2:0] status
  output logic [2:0]           m_axis_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic        pop_mode;
  logic [4:0]  chs_heads;
  logic [7:0]  chs_sectors;
  logic [31:0] max_lba;

  in_item_t in_item;
  cmd_t     q_in, q_out;
  logic     q_push, q_full, q_pop, q_empty;
  result_t  out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_mode    <= 1'b1;
      chs_heads   <= 5'd16;
      chs_sectors <= 8'd63;
      max_lba     <= LBA28_MASK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POP_MODE:    pop_mode    <= cfg_data[0];
        CFG_CHS_HEADS:   chs_heads   <= cfg_data[4:0];
        CFG_CHS_SECTORS: chs_sectors <= cfg_data[7:0];
        CFG_MAX_LBA:     max_lba     <= cfg_data;
      endcase
    end
  end

  assign in_item.func            = s_axis_tuser[0];
  assign in_item.class_write     = s_axis_tuser[1];
  assign in_item.class_read      = s_axis_tuser[2];
  assign in_item.addr_28bit      = s_axis_tuser[3];
  assign in_item.addr_48bit      = s_axis_tuser[4];
  assign in_item.no_sector_count = s_axis_tuser[5];
  assign in_item.fis_word1       = s_axis_tdata[31:0];
  assign in_item.fis_lba_high    = s_axis_tdata[39:32];
  assign in_item.fis_count       = s_axis_tdata[55:40];

  rpcq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_item     (in_item),
    .chs_heads   (chs_heads),
    .chs_sectors (chs_sectors),
    .max_lba     (max_lba),
    .q_push      (q_push),
    .q_data      (q_in),
    .q_full      (q_full)
  );

  rpcq_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  rpcq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_mode  (pop_mode),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {6'd0, out_res.is_write, out_res.cnt, out_res.lba};

  a_no_q_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue written while full");

  a_no_q_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command queue read while empty");

  a_non_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_POPPED) |-> (m_axis_tdata == '0))
    else $error("payload not zero on a non-pop result");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_POPPED) |-> (m_axis_tdata[48:32] != '0))
    else $error("popped command shows a zero count");

endmodule

`default_nettype wire
